// ----- src/sitdc_pkg.sv -----
// Shared types and constants for the signed binary to decimal character formatter.
package sitdc_pkg;

    localparam int MAX_DIGITS    = 10;
    localparam int MAG_W         = 32;
    localparam int COUNT_W       = 4;
    localparam int CHAR_W        = 6;
    localparam int DIGIT_W       = 4;
    localparam int STEP_W        = $clog2(MAG_W);
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- src/sitdc_bcd_cell.sv -----
// One decimal digit cell of the shift-and-add-three binary to BCD chain.
module sitdc_bcd_cell (
    input  logic                clk,
    input  sitdc_pkg::cell_ctrl_t ctrl,
    input  logic                carry_in,
    output logic                carry_out,
    output sitdc_pkg::digit_t   digit
);

    sitdc_pkg::digit_t digit_reg;
    sitdc_pkg::digit_t digit_next;
    sitdc_pkg::digit_t adjusted;

    always_comb
    begin
        if (digit_reg >= sitdc_pkg::DIGIT_FIVE)
        begin
            adjusted = digit_reg + sitdc_pkg::DIGIT_ADJ;
        end
        else
        begin
            adjusted = digit_reg;
        end
        carry_out = adjusted[sitdc_pkg::DIGIT_W-1];
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adjusted[sitdc_pkg::DIGIT_W-2:0], carry_in};
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ----- src/signed_int_to_decimal_chars_top.sv -----
// Sequence: a word is taken in ST_IDLE, shifted through the digit cell chain in ST_CONV, checked
// in ST_PREP, and then emitted from ST_EMIT as n + 1 characters, n being the clamped count.
// One character is emitted per cycle while the output does not stall; a new word is taken only
// once the last character of the previous word has been issued and the sequencer is back in idle.
// Reset: rst_n clears the sequencer and the output valid; the block then waits for a word.
module signed_int_to_decimal_chars_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: number[31:0], digit_count[35:32], zero fill.
    input  logic [sitdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: out_char[5:0], zero fill.
    output logic [sitdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    // Fields from bit 0: overflowed.
    output logic                                m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [sitdc_pkg::STEP_W-1:0] step_reg;
    logic [sitdc_pkg::STEP_W-1:0] step_next;
    logic [sitdc_pkg::MAG_W-1:0] mag_reg;
    logic [sitdc_pkg::MAG_W-1:0] mag_next;
    logic neg_reg;
    logic neg_next;
    sitdc_pkg::count_t n_reg;
    sitdc_pkg::count_t n_next;
    sitdc_pkg::count_t pos_reg;
    sitdc_pkg::count_t pos_next;
    sitdc_pkg::count_t first_reg;
    sitdc_pkg::count_t first_next;
    logic ovf_reg;
    logic ovf_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic [sitdc_pkg::CHAR_W-1:0] out_char_reg;
    logic [sitdc_pkg::CHAR_W-1:0] out_char_next;
    logic out_last_reg;
    logic out_last_next;
    logic out_ovf_reg;
    logic out_ovf_next;

    logic [sitdc_pkg::MAG_W-1:0] in_number;
    sitdc_pkg::count_t in_count;
    sitdc_pkg::cell_ctrl_t cell_ctrl;
    sitdc_pkg::digit_t cells [sitdc_pkg::MAX_DIGITS];
    logic carry [sitdc_pkg::MAX_DIGITS];
    logic chk_ovf;
    sitdc_pkg::count_t chk_top;
    sitdc_pkg::count_t pos_inc;
    sitdc_pkg::count_t cell_idx;
    sitdc_pkg::digit_t cur_digit;
    logic [sitdc_pkg::CHAR_W-1:0] cur_char;

    assign in_number = s_axis_tdata[sitdc_pkg::MAG_W-1:0];
    assign in_count  = s_axis_tdata[sitdc_pkg::MAG_W +: sitdc_pkg::COUNT_W];

    genvar gi;
    generate
        for (gi = 0; gi < sitdc_pkg::MAX_DIGITS; gi++)
        begin : g_cell
            logic cin;
            if (gi == 0)
            begin : g_first
                assign cin = mag_reg[sitdc_pkg::MAG_W-1];
            end
            else
            begin : g_rest
                assign cin = carry[gi-1];
            end
            sitdc_bcd_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .carry_in  (cin),
                .carry_out (carry[gi]),
                .digit     (cells[gi])
            );
        end
    endgenerate

    // Overflow means a nonzero digit at or above the field width; the highest
    // nonzero digit below the width marks where the sign goes.
    always_comb
    begin
        chk_ovf = 1'b0;
        chk_top = '0;
        for (int i = 1; i < sitdc_pkg::MAX_DIGITS; i++)
        begin
            if (cells[i] != '0)
            begin
                if (sitdc_pkg::COUNT_W'(i) >= n_reg)
                begin
                    chk_ovf = 1'b1;
                end
                else
                begin
                    chk_top = sitdc_pkg::COUNT_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        pos_inc  = pos_reg + 1'b1;
        cell_idx = n_reg - pos_reg;
        if (ovf_reg)
        begin
            cur_digit = sitdc_pkg::DIGIT_NINE;
        end
        else
        begin
            cur_digit = cells[cell_idx];
        end
        if (pos_inc < first_reg)
        begin
            cur_char = sitdc_pkg::CH_SPACE;
        end
        else if (pos_inc == first_reg)
        begin
            cur_char = neg_reg ? sitdc_pkg::CH_MINUS : sitdc_pkg::CH_SPACE;
        end
        else
        begin
            cur_char = sitdc_pkg::CH_ZERO + {2'b00, cur_digit};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        cell_ctrl      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next = in_number[sitdc_pkg::MAG_W-1];
                    if (in_number[sitdc_pkg::MAG_W-1])
                    begin
                        mag_next = ~in_number + 1'b1;
                    end
                    else
                    begin
                        mag_next = in_number;
                    end
                    if (in_count == '0)
                    begin
                        n_next = sitdc_pkg::COUNT_W'(1);
                    end
                    else if (in_count > sitdc_pkg::COUNT_W'(sitdc_pkg::MAX_DIGITS))
                    begin
                        n_next = sitdc_pkg::COUNT_W'(sitdc_pkg::MAX_DIGITS);
                    end
                    else
                    begin
                        n_next = in_count;
                    end
                    step_next       = '0;
                    cell_ctrl.clear = 1'b1;
                    state_next      = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_ctrl.shift = 1'b1;
                mag_next        = {mag_reg[sitdc_pkg::MAG_W-2:0], 1'b0};
                step_next       = step_reg + 1'b1;
                if (step_reg == sitdc_pkg::STEP_W'(sitdc_pkg::MAG_W - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                ovf_next   = chk_ovf;
                first_next = chk_ovf ? sitdc_pkg::COUNT_W'(1) : n_reg - chk_top;
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = cur_char;
                    out_last_next  = (pos_reg == n_reg);
                    out_ovf_next   = ovf_reg;
                    pos_next       = pos_inc;
                    if (pos_reg == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        n_reg        <= n_next;
        pos_reg      <= pos_next;
        first_reg    <= first_next;
        ovf_reg      <= ovf_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sitdc_pkg::OUT_TDATA_W - sitdc_pkg::CHAR_W){1'b0}}, out_char_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule
